[hdl/lpr_pkg.sv]
// Shared constants, payload structs and control types for the LRU page replacement block.
package lpr_pkg;

  // Frame table size and page width
  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  // Cells per chain segment; a segment ripples combinationally
  localparam int GROUP_SIZE = 4;
  localparam int NUM_GROUPS = (MAX_FRAMES + GROUP_SIZE - 1) / GROUP_SIZE;

  // Derived widths
  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W   = 5;
  localparam int FIDX_W  = 4;
  localparam int FAULT_W = 32;

  // Oldest rank a frame can reach
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

  // Input word
  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_access;
  } req_t;

  // Result word
  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;
    logic                 run_end;
  } rsp_t;

  // Partial lookup result handed from cell to cell
  typedef struct packed {
    logic                 hit_found;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic [RANK_W-1:0]    best_rank;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } carry_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic                 en;
    logic                 clear;
    logic [IDX_W-1:0]     frame;
    logic [RANK_W-1:0]    limit;
    logic                 age_all;
    logic                 write;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_COMBINE,
    ST_UPDATE
  } lpr_state_e;

endpackage

[hdl/lpr_cell.sv]
// One frame of the table: page, valid and recency rank, with its step of the lookup chain.
module lpr_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lpr_pkg::IDX_W-1:0]      cell_idx_i,
  input  logic [lpr_pkg::CNT_W-1:0]      n_i,
  input  logic [lpr_pkg::PAGE_BITS-1:0]  page_i,
  input  lpr_pkg::carry_t                carry_i,
  input  lpr_pkg::upd_t                  upd_i,
  output lpr_pkg::carry_t                carry_o
);
  import lpr_pkg::*;

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q;
  logic                 in_use;
  logic                 match;
  logic                 sel;

  assign in_use = (CNT_W'(cell_idx_i) < n_i);
  assign match  = in_use && valid_q && (page_q == page_i);
  assign sel    = (upd_i.frame == cell_idx_i);

  // Pass on the first hit and the oldest frame seen so far;
  // frame 0 stands as the oldest until an older frame turns up
  always_comb begin
    carry_o = carry_i;
    if (!carry_i.hit_found && match) begin
      carry_o.hit_found = 1'b1;
      carry_o.hit_idx   = cell_idx_i;
      carry_o.hit_rank  = rank_q;
    end
    if (in_use && valid_q &&
        ((rank_q > carry_i.best_rank) || (cell_idx_i == '0))) begin
      carry_o.best_rank = rank_q;
      carry_o.best_idx  = cell_idx_i;
      carry_o.best_page = page_q;
    end
  end

  // Age, promote or clear the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.clear) begin
        valid_q <= 1'b0;
        rank_q  <= '0;
      end else if (sel) begin
        rank_q <= '0;
        if (upd_i.write) begin
          valid_q <= 1'b1;
        end
      end else if (valid_q && (upd_i.age_all || (rank_q < upd_i.limit)) &&
                   (rank_q != RANK_MAX)) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  // Load the new page on a fill or replacement
  always_ff @(posedge clk_i) begin
    if (upd_i.en && !upd_i.clear && upd_i.write && sel) begin
      page_q <= upd_i.page;
    end
  end

endmodule

[hdl/lpr_ctrl.sv]
// Sequencer: takes words in, merges segment results, picks the frame and counts faults.
module lpr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  lpr_pkg::req_t             req_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_data_i,
  input  lpr_pkg::carry_t           grp_i [lpr_pkg::NUM_GROUPS],
  output logic [lpr_pkg::CNT_W-1:0] n_o,
  output logic [lpr_pkg::PAGE_BITS-1:0] page_o,
  output lpr_pkg::upd_t             upd_o,
  output logic                      rsp_valid_o,
  output lpr_pkg::rsp_t             rsp_o
);
  import lpr_pkg::*;

  // Decision taken after the merge
  typedef struct packed {
    logic                 hit;
    logic                 fill;
    logic [IDX_W-1:0]     frame;
    logic [RANK_W-1:0]    limit;
    logic                 write;
    logic                 evict;
    logic [PAGE_BITS-1:0] evict_page;
  } dec_t;

  lpr_state_e           state_q, state_d;
  req_t                 req_q;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     n_clamp;
  logic [CFG_W-1:0]     frame_count_q;
  logic [CNT_W-1:0]     fill_q;
  logic [FAULT_W-1:0]   faults_q;
  logic [FAULT_W-1:0]   faults_nxt;
  carry_t               grp_q [NUM_GROUPS];
  dec_t                 dec_q, dec_d;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;
  logic                 accept;
  logic                 grp_load;
  logic                 dec_load;
  logic                 upd_go;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = !busy_o;
  assign n_o         = n_q;
  assign page_o      = req_q.page_number;
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (start_i) state_d = ST_GROUP;
      ST_GROUP:   state_d = ST_COMBINE;
      ST_COMBINE: state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy_o   = 1'b1;
    grp_load = 1'b0;
    dec_load = 1'b0;
    upd_go   = 1'b0;
    case (state_q)
      ST_IDLE:    busy_o   = 1'b0;
      ST_GROUP:   grp_load = 1'b1;
      ST_COMBINE: dec_load = 1'b1;
      ST_UPDATE:  upd_go   = 1'b1;
      default:    busy_o   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Clamp the frame count to between one and the table size
  always_comb begin
    if (frame_count_q == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
      n_clamp = CNT_W'(MAX_FRAMES);
    end else begin
      n_clamp = CNT_W'(frame_count_q);
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= CFG_W'(MAX_FRAMES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_count_q <= cfg_data_i;
    end
  end

  // Hold the accepted word and frame count
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      n_q   <= n_clamp;
    end
  end

  // Capture segment results
  always_ff @(posedge clk_i) begin
    if (grp_load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_q[g] <= grp_i[g];
      end
    end
  end

  // Merge segments and choose hit, fill or replacement;
  // the first segment always carries frame 0 as the oldest candidate
  always_comb begin
    logic                 found;
    logic [IDX_W-1:0]     h_idx;
    logic [RANK_W-1:0]    h_rank;
    logic [RANK_W-1:0]    b_rank;
    logic [IDX_W-1:0]     b_idx;
    logic [PAGE_BITS-1:0] b_page;
    found  = 1'b0;
    h_idx  = '0;
    h_rank = '0;
    b_rank = grp_q[0].best_rank;
    b_idx  = grp_q[0].best_idx;
    b_page = grp_q[0].best_page;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (!found && grp_q[g].hit_found) begin
        found  = 1'b1;
        h_idx  = grp_q[g].hit_idx;
        h_rank = grp_q[g].hit_rank;
      end
      if (grp_q[g].best_rank > b_rank) begin
        b_rank = grp_q[g].best_rank;
        b_idx  = grp_q[g].best_idx;
        b_page = grp_q[g].best_page;
      end
    end
    dec_d = '0;
    if (found) begin
      dec_d.hit   = 1'b1;
      dec_d.frame = h_idx;
      dec_d.limit = h_rank;
    end else if (fill_q < n_q) begin
      dec_d.fill  = 1'b1;
      dec_d.frame = IDX_W'(fill_q);
      dec_d.write = 1'b1;
    end else begin
      dec_d.frame      = b_idx;
      dec_d.limit      = b_rank;
      dec_d.write      = 1'b1;
      dec_d.evict      = 1'b1;
      dec_d.evict_page = b_page;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_load) begin
      dec_q <= dec_d;
    end
  end

  // Broadcast the update to the cells
  always_comb begin
    upd_o.en      = upd_go;
    upd_o.clear   = upd_go && req_q.last_access;
    upd_o.frame   = dec_q.frame;
    upd_o.limit   = dec_q.limit;
    upd_o.age_all = dec_q.fill;
    upd_o.write   = dec_q.write;
    upd_o.page    = req_q.page_number;
  end

  // Saturating fault count
  always_comb begin
    faults_nxt = faults_q;
    if (!dec_q.hit && (faults_q != '1)) begin
      faults_nxt = faults_q + 1'b1;
    end
  end

  // Advance fill and fault counters; drop them at the end of a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      faults_q <= '0;
    end else if (upd_go) begin
      if (req_q.last_access) begin
        fill_q   <= '0;
        faults_q <= '0;
      end else begin
        faults_q <= faults_nxt;
        if (dec_q.fill) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // Result word and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= upd_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      rsp_q.hit           <= dec_q.hit;
      rsp_q.frame_index   <= FIDX_W'(dec_q.frame);
      rsp_q.evicted_valid <= dec_q.evict;
      rsp_q.evicted_page  <= dec_q.evict_page;
      rsp_q.fault_count   <= faults_nxt;
      rsp_q.run_end       <= req_q.last_access;
    end
  end

endmodule

[hdl/lru_page_replacement.sv]
// A word accepted while idle passes the segment capture, merge and update states before its strobe.
// A new word is taken only once the last one is through; busy_o covers segment ripple, merge and table update.
// The cell chain ripples in segments of four cells, so the lookup costs two register stages.
// Results are strobed for one cycle only; the receiver cannot stall.
// Reset (async, active low) empties every frame, zeroes the counters and sets the
// frame count to the table size; no clearing pass is needed.
module lru_page_replacement (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  lpr_pkg::req_t             req_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      rsp_valid_o,
  output lpr_pkg::rsp_t             rsp_o
);
  import lpr_pkg::*;

  carry_t               chain [MAX_FRAMES];
  carry_t               grp [NUM_GROUPS];
  upd_t                 upd;
  logic [CNT_W-1:0]     n;
  logic [PAGE_BITS-1:0] page;

  // Row of frame cells, chained within each segment
  for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
    carry_t cin;
    if (j % GROUP_SIZE == 0) begin : g_head
      assign cin = '0;
    end else begin : g_link
      assign cin = chain[j-1];
    end
    lpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(j)),
      .n_i        (n),
      .page_i     (page),
      .carry_i    (cin),
      .upd_i      (upd),
      .carry_o    (chain[j])
    );
  end

  // Tap the tail of each segment
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_tap
    localparam int LastJ = ((g + 1) * GROUP_SIZE - 1 < MAX_FRAMES) ?
                           ((g + 1) * GROUP_SIZE - 1) : (MAX_FRAMES - 1);
    assign grp[g] = chain[LastJ];
  end

  lpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .grp_i       (grp),
    .n_o         (n),
    .page_o      (page),
    .upd_o       (upd),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTHESIS
  // Every accepted word is followed by its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 rsp_valid_o)
    else $error("result strobe missing after accepted word");

  // The block is ready again while its result is shown
  a_ready_on_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy_o)
    else $error("busy while result strobe is high");

  // A hit never replaces a page
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.hit) |-> !rsp_o.evicted_valid)
    else $error("eviction reported on a hit");

  // No eviction means a zero evicted page
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.evicted_valid) |-> (rsp_o.evicted_page == '0))
    else $error("evicted page not zero without eviction");
`endif

endmodule

[test/lru_checker.sv]
`timescale 1ns / 1ps
// Checker for the LRU page replacement block: predicts every result word and compares it.
module lru_checker
  import lpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  req_t             req_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             rsp_valid_i,
  input  rsp_t             rsp_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Predicted frame table and run counters
  logic [PAGE_BITS-1:0] page_tbl  [MAX_FRAMES];
  logic                 valid_tbl [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_tbl  [MAX_FRAMES];
  int                   filled;
  logic [FAULT_W-1:0]   fault_tally;
  logic [CFG_W-1:0]     frames_cfg;

  // Results still owed by the block, oldest first
  rsp_t                 owed_q[$];
  rsp_t                 want;
  int                   fails;

  // Empty every frame and restart the fault count
  function automatic void clear_run();
    for (int j = 0; j < MAX_FRAMES; j++) begin
      page_tbl[j]  = '0;
      valid_tbl[j] = 1'b0;
      rank_tbl[j]  = '0;
    end
    filled      = 0;
    fault_tally = '0;
  endfunction

  // Make frame f the youngest; valid frames younger than limit grow one step older
  function automatic void promote(int f, int limit);
    for (int j = 0; j < MAX_FRAMES; j++) begin
      if (j != f && valid_tbl[j] && int'(rank_tbl[j]) < limit && rank_tbl[j] < RANK_MAX)
        rank_tbl[j] = rank_tbl[j] + 1'b1;
    end
    rank_tbl[f] = '0;
  endfunction

  // Look up one page reference, update the table and return the result word it yields
  function automatic rsp_t apply_reference(req_t r);
    int   n;
    int   f;
    int   best;
    logic found;
    rsp_t res;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    found = 1'b0;
    f     = 0;
    res   = '0;
    for (int j = 0; j < n; j++) begin
      if (!found && valid_tbl[j] && page_tbl[j] == r.page_number) begin
        found = 1'b1;
        f     = j;
      end
    end
    if (found) begin
      promote(f, int'(rank_tbl[f]));
    end else begin
      if (filled < n) begin
        // Fill the next empty frame in index order
        f            = filled;
        filled       = filled + 1;
        valid_tbl[f] = 1'b1;
        page_tbl[f]  = r.page_number;
        promote(f, MAX_FRAMES);
      end else begin
        // Replace the oldest frame; lowest index wins a tie
        best = 0;
        f    = 0;
        for (int j = 0; j < n; j++) begin
          if (valid_tbl[j] && int'(rank_tbl[j]) > best) begin
            best = int'(rank_tbl[j]);
            f    = j;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = page_tbl[f];
        page_tbl[f]       = r.page_number;
        valid_tbl[f]      = 1'b1;
        promote(f, int'(rank_tbl[f]));
      end
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
    end
    res.hit         = found;
    res.frame_index = FIDX_W'(f);
    res.fault_count = fault_tally;
    res.run_end     = r.last_access;
    if (r.last_access) clear_run();
    return res;
  endfunction

  // Report one field that disagrees
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fails = fails + 1;
    end
  endfunction

  // Watch the three channels on every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      frames_cfg = CFG_W'(MAX_FRAMES);
      owed_q.delete();
      fails      = 0;
    end else begin
      // Compare the returned word against the oldest prediction
      if (rsp_valid_i) begin
        if (owed_q.size() == 0) begin
          $error("result word with no prediction waiting");
          fails = fails + 1;
        end else begin
          want = owed_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp_i.hit));
          check_field("frame_index", 32'(want.frame_index), 32'(rsp_i.frame_index));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(rsp_i.evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_i.evicted_page));
          check_field("fault_count", 32'(want.fault_count), 32'(rsp_i.fault_count));
          check_field("run_end", 32'(want.run_end), 32'(rsp_i.run_end));
        end
      end
      // Latch a frame count write
      if (cfg_valid_i && cfg_ready_i) frames_cfg = cfg_data_i;
      // Predict each accepted reference
      if (start_i && !busy_i) owed_q.push_back(apply_reference(req_i));
    end
    fail_count_o <= fails;
    pending_o    <= owed_q.size();
  end

endmodule

[test/tb_lru_page_replacement.sv]
`timescale 1ns / 1ps
// Testbench top: drives page references and frame count writes, then gives the verdict.
module tb_lru_page_replacement;
  import lpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic             busy_o;
  req_t             req_i       = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             rsp_valid_o;
  rsp_t             rsp_o;

  int               fail_count;
  int               pending;
  int unsigned      cycle_count = 0;
  int               sender_idle_pct = 0;
  logic [PAGE_BITS-1:0] pool_base = '0;
  int               pool_span = 1;

  lru_page_replacement DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  lru_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one reference word, idling first at the sender's rate, and hold it until taken
  task automatic send_ref(input logic [PAGE_BITS-1:0] page, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= '{page_number: page, last_access: last};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drop start and wait until every predicted word has come back
  task automatic go_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the frame count once the block is idle
  task automatic write_frames(input logic [CFG_W-1:0] value);
    go_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Frame count for a new segment, extremes and out-of-range values included
  function automatic logic [CFG_W-1:0] pick_frames();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(MAX_FRAMES);
      3:       return CFG_W'($urandom_range(MAX_FRAMES + 1, 31));
      default: return CFG_W'($urandom_range(2, MAX_FRAMES - 1));
    endcase
  endfunction

  // One random reference: mostly from a small working set so hits and evictions are common
  task automatic random_ref();
    int                   sel;
    logic [PAGE_BITS-1:0] page;
    sel = $urandom_range(99);
    if (sel < 75)
      page = pool_base + PAGE_BITS'($urandom_range(pool_span));
    else if (sel < 85)
      page = $urandom_range(1) ? '1 : '0;
    else
      page = PAGE_BITS'($urandom);
    send_ref(page, $urandom_range(39) == 0);
  endtask

  initial begin
    int idle_plan [3];
    idle_plan = '{28, 64, 0};

    // Hold reset, then release it
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two frames: fill, hit, evict the older one, end the run
    write_frames(CFG_W'(2));
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0009, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0009, 1'b0);
    send_ref(16'h0000, 1'b1);

    // Zero frames acts as one: the first miss fills frame 0, later misses replace it on an all-equal rank
    write_frames('0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0004, 1'b0);
    send_ref(16'h0004, 1'b1);

    // Count above the table size acts as the full table
    write_frames('1);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b1);

    // Shrink and grow the frame count in the middle of a run
    write_frames(CFG_W'(4));
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0004, 1'b0);
    write_frames(CFG_W'(2));
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0003, 1'b0);
    write_frames(CFG_W'(MAX_FRAMES));
    send_ref(16'h0006, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0007, 1'b1);

    // Random segments under three sender idling rates; runs may span a count change
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      for (int seg = 0; seg < 7; seg++) begin
        write_frames(pick_frames());
        pool_base = PAGE_BITS'($urandom);
        pool_span = $urandom_range(1, 20);
        repeat (50) random_ref();
      end
    end

    go_quiet();
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
